### sv/lmed_pkg.sv
// shared constants for the list-mode event decoder
`timescale 1ns / 1ps

package lmed_pkg;

  // sampling-rate mode codes
  localparam logic [1:0] RateMode100  = 2'd0;
  localparam logic [1:0] RateMode250  = 2'd1;
  localparam logic [1:0] RateMode500  = 2'd2;
  localparam logic [1:0] RateMode500b = 2'd3;

  // field widths
  localparam int unsigned PosWidth   = 14;
  localparam int unsigned CfdWidth   = 22;
  localparam int unsigned TsWidth    = 52;
  localparam int unsigned RawTsWidth = 48;

  // event layout
  localparam logic [PosWidth-1:0] MinEventWords = 14'd4;
  localparam logic [PosWidth-1:0] PosHeader0    = 14'd0;
  localparam logic [PosWidth-1:0] PosHeader1    = 14'd1;
  localparam logic [PosWidth-1:0] PosHeader2    = 14'd2;
  localparam logic [PosWidth-1:0] PosHeader3    = 14'd3;

  // slot numbering starts at two
  localparam logic [4:0] SlotOffset = 5'd2;

  // cfd sign terms in q.16 ns
  localparam logic [CfdWidth-1:0] Cfd250Sign = 22'h040000;
  localparam logic [CfdWidth-1:0] Cfd500Step = 22'h020000;

endpackage

### sv/list_mode_event_decoder_unit.sv
// list-mode event decoder: tracks event position, holds header words, emits one record per event
`timescale 1ns / 1ps

// Takes one 32-bit list-mode word per clock and keeps its own position inside
// each event. Header words 0 to 2 are held in registers; when header word 3
// is accepted the record is formed in the same cycle and shown on the output
// register in the next cycle, and words keep coming at one word per clock
// while the output is taken. Trace words after the header are consumed at the
// same rate until the event length taken from header word 0 is reached (a
// length below four is used as four and flagged). The input side stalls only
// when header word 3 arrives while the previous record still waits in the
// output register and is not being taken in that cycle. rate_mode selects the
// CFD decoding and the timestamp scale (8 ns at 250 MHz, else 10 ns); write it
// only while no event is in flight.
module list_mode_event_decoder_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        data_word_i,
  input  logic               packet_end_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [4:0]  module_index_o,
  output logic [3:0]         channel_number_o,
  output logic [15:0]        energy_value_o,
  output logic signed [21:0] cfd_fraction_o,
  output logic               cfd_forced_o,
  output logic [51:0]        timestamp_ns_o,
  output logic [13:0]        event_words_o,
  output logic               length_error_o
);

  localparam int unsigned PW = lmed_pkg::PosWidth;
  localparam int unsigned CW = lmed_pkg::CfdWidth;
  localparam int unsigned TW = lmed_pkg::TsWidth;

  // control state
  logic [1:0]    rate_q;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] len_q, len_d;
  logic          out_valid_q, out_valid_d;

  // held header fields
  logic [7:0]    h0_id_q;
  logic          h0_short_q;
  logic [31:0]   h1_q;
  logic [31:0]   h2_q;

  // result register
  logic [4:0]    module_index_q;
  logic [3:0]    channel_q;
  logic [15:0]   energy_q;
  logic [CW-1:0] cfd_q, cfd_d;
  logic          forced_q, forced_d;
  logic [TW-1:0] ts_q, ts_d;
  logic [PW-1:0] event_words_q;
  logic          length_error_q;

  logic          in_fire;
  logic          emit;
  logic          at_header3;
  logic [PW:0]   pos_inc;
  logic [PW-1:0] hdr_len;
  logic          hdr_short;
  logic [lmed_pkg::RawTsWidth-1:0] ts_raw;
  logic [TW-1:0] ts_x8;
  logic [2:0]    cfd_s500;

  assign at_header3 = (pos_q == lmed_pkg::PosHeader3);
  // only the record word needs room in the output register
  assign in_ready_o = !at_header3 || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit       = in_fire && at_header3;

  assign hdr_len   = data_word_i[30:17];
  assign hdr_short = (hdr_len < lmed_pkg::MinEventWords);
  assign pos_inc   = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};

  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    if (in_fire) begin
      if (pos_q == lmed_pkg::PosHeader0) begin
        len_d = hdr_short ? lmed_pkg::MinEventWords : hdr_len;
      end
      if (packet_end_i || (pos_inc >= {1'b0, len_q})) begin
        pos_d = '0;
      end else begin
        pos_d = pos_inc[PW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  // cfd decode, all sums wrap at the field width
  assign cfd_s500 = h2_q[31:29];
  always_comb begin
    unique case (rate_q)
      lmed_pkg::RateMode100: begin
        forced_d = h2_q[31];
        cfd_d    = (CW'(h2_q[30:16]) << 4) + (CW'(h2_q[30:16]) << 2);
      end
      lmed_pkg::RateMode250: begin
        forced_d = h2_q[31];
        cfd_d    = (CW'(h2_q[29:16]) << 4) - (h2_q[30] ? lmed_pkg::Cfd250Sign : '0);
      end
      lmed_pkg::RateMode500, lmed_pkg::RateMode500b: begin
        forced_d = (cfd_s500 == 3'd7);
        cfd_d    = (CW'(h2_q[28:16]) << 4) + (CW'(cfd_s500) << 17)
                   - lmed_pkg::Cfd500Step;
      end
      default: begin
        forced_d = 1'b0;
        cfd_d    = '0;
      end
    endcase
    if (forced_d) begin
      cfd_d = '0;
    end
  end

  // times 8, or times 8 plus times 2
  assign ts_raw = {h2_q[15:0], h1_q};
  assign ts_x8  = TW'(ts_raw) << 3;
  assign ts_d   = (rate_q == lmed_pkg::RateMode250) ? ts_x8 : ts_x8 + (TW'(ts_raw) << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= lmed_pkg::RateMode100;
      pos_q       <= '0;
      len_q       <= lmed_pkg::MinEventWords;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      pos_q       <= pos_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      unique case (pos_q)
        lmed_pkg::PosHeader0: begin
          h0_id_q    <= data_word_i[7:0];
          h0_short_q <= hdr_short;
        end
        lmed_pkg::PosHeader1: h1_q <= data_word_i;
        lmed_pkg::PosHeader2: h2_q <= data_word_i;
        default: ;
      endcase
    end
    if (emit) begin
      module_index_q <= {1'b0, h0_id_q[7:4]} - lmed_pkg::SlotOffset;
      channel_q      <= h0_id_q[3:0];
      energy_q       <= data_word_i[15:0];
      cfd_q          <= cfd_d;
      forced_q       <= forced_d;
      ts_q           <= ts_d;
      event_words_q  <= len_q;
      length_error_q <= h0_short_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign module_index_o   = $signed(module_index_q);
  assign channel_number_o = channel_q;
  assign energy_value_o   = energy_q;
  assign cfd_fraction_o   = $signed(cfd_q);
  assign cfd_forced_o     = forced_q;
  assign timestamp_ns_o   = ts_q;
  assign event_words_o    = event_words_q;
  assign length_error_o   = length_error_q;

  a_len_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q >= lmed_pkg::MinEventWords)
    else $error("event length below minimum");

  a_pos_in_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < len_q)
    else $error("word position beyond event length");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_q)
    else $error("record word accepted but no result shown");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit && out_valid_q && !out_ready_i))
    else $error("pending record overwritten");

  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && length_error_q) |-> (event_words_q == lmed_pkg::MinEventWords))
    else $error("short length not clamped");

endmodule
